>>> rtl/kmw_pkg.sv
// package: constants, types and states of the spanning tree weight block
package kmw_pkg;
  localparam int VBITS = 10;
  localparam int EBITS = 12;
  localparam int CBITS = 13;
  localparam int WBITS = 16;
  localparam int KBITS = 36;
  localparam int NVBITS = 11;
  localparam int MAX_VERTICES = 1024;
  localparam int MAX_EDGES = 4096;
  localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;

  typedef logic [KBITS-1:0] key_t;

  typedef enum logic [4:0] {
    S_LOAD, S_HEAP_START, S_SIFT_RD, S_SIFT_W1, S_SIFT_W2, S_SIFT_CMP,
    S_SWAP, S_EXTRACT, S_EXT_RD, S_EXT_SW,
    S_UF_CLR, S_SCAN_RD, S_SCAN_W, S_FIND_RD, S_FIND_W, S_FIND_CHK,
    S_COMP_RD, S_COMP_W, S_COMP_WR, S_JOIN_RD, S_JOIN_W, S_JOIN_DO, S_OUT
  } state_e;
endpackage

>>> rtl/kmw_if.sv
// valid/ready channel interface
interface kmw_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/kmw_ram.sv
// generic single-port ram with registered read
module kmw_ram #(
  parameter int AW = 12,
  parameter int DW = 36
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);
  logic [DW-1:0] mem [2**AW];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule

>>> rtl/kruskal_mst_weight.sv
// top level: edge loader, heap sort and union-find sequencer
// usage:
//   in_if carries one edge per request {last_edge, edge_weight, dst_vertex, src_vertex}
//   out_if carries {connected, edges_taken, mst_weight}, one request per graph
//   apb port holds vertex_count at address 0; write it only while the block is idle
// throughput: during loading one edge is taken each cycle; the last edge closes the
//   graph and no further edge is accepted until its result has been taken
// sort and scan: after the last edge the block sorts the stored edges with an in-place
//   heap sort on one edge ram port, sifting level by level and then extracting, clears
//   all 1024 entries of the union-find tables, then scans the sorted edges: an edge with
//   an endpoint out of range is skipped, an edge inside one set is dropped and a joining
//   edge is added, with extra parent hops and path compression on each find
// the edge ram, parent ram and rank ram each have one port
// reset: control cleared, edge count zero, vertex_count one; the tables are
//   cleared before every scan so no pass is needed after reset
// receiver stall: the result waits in its register and no edge is accepted
//   until it is taken
module kruskal_mst_weight (
  input  logic        clk_i,
  input  logic        rst_ni,
  kmw_if.sink         in_if,
  kmw_if.source       out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import kmw_pkg::*;

  state_e state_q, state_d;
  logic [NVBITS-1:0] vcount_q;
  logic [CBITS-1:0]  ecount_q, ecount_d;
  logic [CBITS-1:0]  i_q, i_d;      // heap build index / extraction index / scan index
  logic [CBITS-1:0]  end_q, end_d;
  logic [EBITS-1:0]  root_q, root_d;
  logic [CBITS:0]    child_q, child_d;
  key_t              kr_q, kr_d, kc_q, kc_d;
  logic              phase_q, phase_d; // 0 build, 1 extract
  logic [VBITS-1:0]  d_q, d_d, r_q, r_d, v_q, v_d, rs_q, rs_d;
  logic              fsel_q, fsel_d; // 0 src, 1 dst
  logic [3:0]        rka_q, rka_d;
  logic [27:0]       wsum_q, wsum_d;
  logic [VBITS-1:0]  taken_q, taken_d;
  logic [NVBITS-1:0] nv;
  logic [VBITS:0]    clr_q, clr_d;

  logic              e_we, p_we, k_we;
  logic [EBITS-1:0]  e_addr;
  key_t              e_wd, e_rd;
  logic [VBITS-1:0]  p_addr, p_wd, p_rd, k_addr;
  logic [3:0]        k_wd, k_rd;

  kmw_ram #(.AW(EBITS), .DW(KBITS)) u_edges (.clk_i, .we_i(e_we), .addr_i(e_addr),
    .wdata_i(e_wd), .rdata_o(e_rd));
  kmw_ram #(.AW(VBITS), .DW(VBITS)) u_parent (.clk_i, .we_i(p_we), .addr_i(p_addr),
    .wdata_i(p_wd), .rdata_o(p_rd));
  kmw_ram #(.AW(VBITS), .DW(4)) u_rank (.clk_i, .we_i(k_we), .addr_i(k_addr),
    .wdata_i(k_wd), .rdata_o(k_rd));

  assign nv = (vcount_q > NVBITS'(MAX_VERTICES)) ? NVBITS'(MAX_VERTICES) : vcount_q;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? {21'b0, vcount_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= NVBITS'(1);
    end else if (psel && penable && pwrite && paddr[2] == REG_VERTEX_COUNT) begin
      vcount_q <= pwdata[NVBITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      ecount_q <= '0;
      taken_q <= '0;
      wsum_q <= '0;
    end else begin
      state_q <= state_d;
      ecount_q <= ecount_d;
      taken_q <= taken_d;
      wsum_q <= wsum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; end_q <= end_d; root_q <= root_d; child_q <= child_d;
    kr_q <= kr_d; kc_q <= kc_d; phase_q <= phase_d;
    d_q <= d_d; r_q <= r_d; v_q <= v_d; rs_q <= rs_d;
    fsel_q <= fsel_d; rka_q <= rka_d; clr_q <= clr_d;
  end

  assign out_if.data = {(NVBITS'(taken_q) + NVBITS'(1)) == nv, taken_q, wsum_q};

  always_comb begin
    state_d = state_q; ecount_d = ecount_q; i_d = i_q; end_d = end_q;
    root_d = root_q; child_d = child_q; kr_d = kr_q; kc_d = kc_q;
    phase_d = phase_q; d_d = d_q; r_d = r_q; v_d = v_q; rs_d = rs_q;
    fsel_d = fsel_q; rka_d = rka_q; clr_d = clr_q; taken_d = taken_q; wsum_d = wsum_q;
    e_we = 1'b0; e_addr = root_q; e_wd = kr_q;
    p_we = 1'b0; p_addr = r_q; p_wd = r_q;
    k_we = 1'b0; k_addr = r_q; k_wd = '0;
    in_if.ready = 1'b0; out_if.valid = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        in_if.ready = 1'b1;
        e_addr = ecount_q[EBITS-1:0];
        e_wd = {in_if.data[35:20], in_if.data[9:0], in_if.data[19:10]};
        if (in_if.valid) begin
          if (ecount_q < CBITS'(MAX_EDGES)) begin
            e_we = 1'b1;
            ecount_d = ecount_q + 1'b1;
          end
          if (in_if.data[36]) begin
            state_d = S_HEAP_START; phase_d = 1'b0;
            i_d = ((ecount_q < CBITS'(MAX_EDGES)) ? ecount_q + 1'b1 : ecount_q) >> 1;
            end_d = (ecount_q < CBITS'(MAX_EDGES)) ? ecount_q + 1'b1 : ecount_q;
          end
        end
      end
      S_HEAP_START: begin
        if (end_q < CBITS'(2)) begin
          state_d = S_UF_CLR; clr_d = '0;
        end else if (i_q == '0) begin
          phase_d = 1'b1; i_d = end_q - 1'b1; state_d = S_EXTRACT;
        end else begin
          root_d = EBITS'(i_q - 1'b1); i_d = i_q - 1'b1; state_d = S_SIFT_RD;
        end
      end
      S_SIFT_RD: begin
        // read root key
        e_addr = root_q; state_d = S_SIFT_W1;
        child_d = (CBITS+1)'({root_q, 1'b1});
      end
      S_SIFT_W1: begin
        kr_d = e_rd;
        if (child_q >= {1'b0, end_q}) begin
          state_d = phase_q ? S_EXTRACT : S_HEAP_START;
        end else begin
          e_addr = child_q[EBITS-1:0]; state_d = S_SIFT_W2;
        end
      end
      S_SIFT_W2: begin
        kc_d = e_rd;
        if (child_q + 1'b1 < {1'b0, end_q}) begin
          e_addr = EBITS'(child_q + 1'b1); state_d = S_SIFT_CMP;
        end else begin
          state_d = S_SWAP;
        end
      end
      S_SIFT_CMP: begin
        if (kc_q < e_rd) begin
          kc_d = e_rd; child_d = child_q + 1'b1;
        end
        state_d = S_SWAP;
      end
      S_SWAP: begin
        if (kr_q < kc_q) begin
          e_we = 1'b1; e_addr = root_q; e_wd = kc_q;
          state_d = S_EXT_SW; // write old root into child next
        end else begin
          state_d = phase_q ? S_EXTRACT : S_HEAP_START;
        end
      end
      S_EXT_SW: begin
        e_we = 1'b1; e_addr = child_q[EBITS-1:0]; e_wd = kr_q;
        root_d = child_q[EBITS-1:0];
        child_d = (CBITS+1)'({child_q[EBITS-1:0], 1'b1});
        if ({child_q[EBITS-1:0], 1'b1} >= {1'b0, end_q}) begin
          state_d = phase_q ? S_EXTRACT : S_HEAP_START;
        end else begin
          // the ram port is busy with the write, read the new child next
          state_d = S_COMP_WR;
        end
      end
      S_EXTRACT: begin
        // swap element 0 and i, then sift 0 over [0,i)
        if (!phase_q || i_q == '0) begin
          state_d = S_UF_CLR; clr_d = '0;
        end else begin
          e_addr = '0; state_d = S_EXT_RD;
        end
      end
      S_EXT_RD: begin
        kr_d = e_rd; e_addr = EBITS'(i_q); state_d = S_COMP_RD;
      end
      S_COMP_RD: begin
        // e_rd holds element i: write it to 0, then old root to i
        kc_d = e_rd; e_we = 1'b1; e_addr = '0; e_wd = e_rd;
        state_d = S_COMP_W;
      end
      S_COMP_W: begin
        e_we = 1'b1; e_addr = EBITS'(i_q); e_wd = kr_q;
        kr_d = kc_q; root_d = '0; end_d = i_q; i_d = i_q - 1'b1;
        child_d = (CBITS+1)'(1);
        if (i_q < CBITS'(2)) state_d = S_EXTRACT;
        else state_d = S_COMP_WR;
      end
      S_COMP_WR: begin
        e_addr = EBITS'(child_q); state_d = S_SIFT_W2;
      end
      S_UF_CLR: begin
        p_we = 1'b1; k_we = 1'b1;
        p_addr = clr_q[VBITS-1:0]; p_wd = clr_q[VBITS-1:0];
        k_addr = clr_q[VBITS-1:0];
        clr_d = clr_q + 1'b1;
        if (clr_q == (VBITS+1)'(MAX_VERTICES - 1)) begin
          state_d = S_SCAN_RD; i_d = '0; wsum_d = '0; taken_d = '0;
        end
      end
      S_SCAN_RD: begin
        if (i_q >= ecount_q || (NVBITS'(taken_q) + NVBITS'(1)) >= nv) begin
          state_d = S_OUT;
        end else begin
          e_addr = EBITS'(i_q); state_d = S_SCAN_W;
        end
      end
      S_SCAN_W: begin
        kr_d = e_rd; d_d = e_rd[9:0];
        i_d = i_q + 1'b1;
        if (NVBITS'(e_rd[19:10]) >= nv || NVBITS'(e_rd[9:0]) >= nv) begin
          state_d = S_SCAN_RD;
        end else begin
          fsel_d = 1'b0; r_d = e_rd[19:10]; v_d = e_rd[19:10]; state_d = S_FIND_RD;
        end
      end
      S_FIND_RD: begin
        p_addr = r_q; state_d = S_FIND_W;
      end
      S_FIND_W: begin
        if (p_rd == r_q) state_d = S_FIND_CHK;
        else begin r_d = p_rd; p_addr = p_rd; state_d = S_FIND_W; end
      end
      S_FIND_CHK: begin
        // r_q is root: compress path from v_q
        if (v_q == r_q) state_d = S_JOIN_RD;
        else begin p_addr = v_q; state_d = S_JOIN_W; end
      end
      S_JOIN_W: begin
        // p_rd = parent of v; redirect v to root
        p_we = 1'b1; p_addr = v_q; p_wd = r_q; v_d = p_rd;
        state_d = S_FIND_CHK;
      end
      S_JOIN_RD: begin
        if (!fsel_q) begin
          rs_d = r_q; fsel_d = 1'b1; r_d = d_q; v_d = d_q; state_d = S_FIND_RD;
        end else if (rs_q == r_q) begin
          state_d = S_SCAN_RD;
        end else begin
          k_addr = rs_q; state_d = S_JOIN_DO; rka_d = '0;
        end
      end
      S_JOIN_DO: begin
        // first visit: k_rd = rank(rs); capture and read rank(rd)
        if (!fsel_q) begin
          if (rka_q > k_rd) begin
            p_we = 1'b1; p_addr = r_q; p_wd = rs_q;
          end else begin
            p_we = 1'b1; p_addr = rs_q; p_wd = r_q;
            if (rka_q == k_rd && k_rd != 4'd15) begin
              k_we = 1'b1; k_addr = r_q; k_wd = k_rd + 1'b1;
            end
          end
          taken_d = taken_q + 1'b1;
          wsum_d = wsum_q + 28'(kr_q[35:20]);
          state_d = S_SCAN_RD;
        end else begin
          rka_d = k_rd; fsel_d = 1'b0; k_addr = r_q; state_d = S_JOIN_DO;
        end
      end
      S_OUT: begin
        out_if.valid = 1'b1;
        if (out_if.ready) begin
          state_d = S_LOAD; ecount_d = '0;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end
endmodule
